// ===== design/msed_pkg.sv =====
// Shared types and constants for the earliest-free multi-server dispatcher.
package msed_pkg;

  // Field widths
  localparam int unsigned TimeW  = 17;
  localparam int unsigned MinW   = 10;
  localparam int unsigned FreeW  = 32;
  localparam int unsigned SumW   = 40;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgDW  = 17;
  localparam int unsigned CfgIW  = 2;

  // Register indexes
  localparam logic [CfgIW-1:0] CFG_SERVERS_IN_USE = 2'd0;
  localparam logic [CfgIW-1:0] CFG_OPEN_TIME      = 2'd1;
  localparam logic [CfgIW-1:0] CFG_CUTOFF_TIME    = 2'd2;
  localparam logic [CfgIW-1:0] CFG_SERVICE_CAP    = 2'd3;

  // Register reset values
  localparam logic [3:0]       SERVERS_RESET = 4'd8;
  localparam logic [TimeW-1:0] OPEN_RESET    = TimeW'(8 * 3600);
  localparam logic [TimeW-1:0] CUTOFF_RESET  = TimeW'(17 * 3600);
  localparam logic [MinW-1:0]  CAP_RESET     = MinW'(60);

  localparam logic [15:0] SEC_PER_MIN = 16'd60;

  // Job classes decided at the front
  typedef enum logic [1:0] {
    KIND_LATE     = 2'd0,
    KIND_ORDER    = 2'd1,
    KIND_DISPATCH = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic [TimeW-1:0] arrival_seconds;
    logic [MinW-1:0]  service_minutes;
  } job_in_t;

  typedef struct packed {
    logic              accepted;
    logic              order_error;
    logic [2:0]        server_index;
    logic [FreeW-1:0]  wait_seconds;
    logic [SumW-1:0]   total_wait;
    logic [CountW-1:0] served_count;
  } job_out_t;

  // Classified job, minutes already capped
  typedef struct packed {
    job_kind_e        kind;
    logic [TimeW-1:0] arrival;
    logic [MinW-1:0]  minutes;
  } job_cls_t;

  typedef struct packed {
    logic [3:0]       servers_in_use;
    logic [TimeW-1:0] open_time;
    logic [TimeW-1:0] cutoff_time;
    logic [MinW-1:0]  service_cap;
  } cfg_t;

endpackage

// ===== design/msed_front.sv =====
// Front end: accepts jobs, caps service time and classifies late, out-of-order or dispatch.
module msed_front import msed_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  job_in_t  in_data_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output job_cls_t push_data_o
);

  logic [TimeW-1:0] last_arrival_q, last_arrival_d;
  logic             late;
  logic             early;
  logic [MinW-1:0]  minutes;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  // Classify the incoming transaction
  always_comb begin
    late    = in_data_i.arrival_seconds > cfg_i.cutoff_time;
    early   = in_data_i.arrival_seconds < last_arrival_q;
    minutes = (in_data_i.service_minutes > cfg_i.service_cap) ? cfg_i.service_cap
                                                              : in_data_i.service_minutes;
    push_data_o.arrival = in_data_i.arrival_seconds;
    push_data_o.minutes = minutes;
    if (late) begin
      push_data_o.kind = KIND_LATE;
    end else if (early) begin
      push_data_o.kind = KIND_ORDER;
    end else begin
      push_data_o.kind = KIND_DISPATCH;
    end
  end

  // Track the last dispatched arrival for the order check
  always_comb begin
    last_arrival_d = last_arrival_q;
    if (in_valid_i && push_ready_i && !late && !early) begin
      last_arrival_d = in_data_i.arrival_seconds;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_arrival_q <= '0;
    end else begin
      last_arrival_q <= last_arrival_d;
    end
  end

endmodule

// ===== design/msed_queue.sv =====
// Two-entry queue of classified jobs between front and back.
module msed_queue import msed_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  job_cls_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output job_cls_t pop_data_o
);

  job_cls_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/msed_back.sv =====
// Back end: earliest-free server search, free-time update, running totals and result register.
module msed_back import msed_pkg::*; #(
  parameter int unsigned MAX_SERVERS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             reload_i,
  input  logic [TimeW-1:0] reload_time_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  job_cls_t         pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output job_out_t         out_data_o
);

  localparam int unsigned Lvl   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned Leafs = 1 << Lvl;
  localparam int unsigned Nodes = 2 * Leafs - 1;

  localparam logic ST_FIND = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic [FreeW-1:0]  free_q [MAX_SERVERS];
  logic              state_q, state_d;
  job_cls_t          job_q;
  logic [FreeW-1:0]  best_q;
  logic [Lvl-1:0]    bidx_q;
  logic [SumW-1:0]   wait_sum_q, wait_sum_d;
  logic [CountW-1:0] count_q, count_d;
  job_out_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [7:0]        n_eff;
  logic [FreeW-1:0]  leaf_val [Leafs];
  logic [FreeW-1:0]  tval [Nodes];
  logic [Lvl-1:0]    tidx [Nodes];
  logic              tact [Nodes];

  logic              upd_go;
  logic              dispatch;
  logic [FreeW-1:0]  arr32;
  logic [FreeW-1:0]  start;
  logic [FreeW-1:0]  wait_s;
  logic [15:0]       svc_sec;
  logic [FreeW:0]    fin_sum;
  logic [FreeW-1:0]  fin;
  logic [SumW:0]     sum_ext;
  logic [Lvl+2:0]    bidx_ext;

  // Clamp the active server count to 1..MAX_SERVERS
  always_comb begin
    if (cfg_i.servers_in_use == 4'd0) begin
      n_eff = 8'd1;
    end else if ({4'd0, cfg_i.servers_in_use} > 8'(MAX_SERVERS)) begin
      n_eff = 8'(MAX_SERVERS);
    end else begin
      n_eff = {4'd0, cfg_i.servers_in_use};
    end
  end

  // Pad the server times to a power of two
  for (genvar g = 0; g < Leafs; g++) begin : g_leaf
    if (g < MAX_SERVERS) begin : g_real
      assign leaf_val[g] = free_q[g];
    end else begin : g_pad
      assign leaf_val[g] = '0;
    end
  end

  // Minimum tree, lower index wins a tie
  always_comb begin
    for (int g = 0; g < Leafs; g++) begin
      tval[Leafs-1+g] = leaf_val[g];
      tidx[Leafs-1+g] = Lvl'(g);
      tact[Leafs-1+g] = 8'(g) < n_eff;
    end
    for (int k = Leafs - 2; k >= 0; k--) begin
      if (tact[2*k+1] && (!tact[2*k+2] || tval[2*k+1] <= tval[2*k+2])) begin
        tval[k] = tval[2*k+1];
        tidx[k] = tidx[2*k+1];
      end else begin
        tval[k] = tval[2*k+2];
        tidx[k] = tidx[2*k+2];
      end
      tact[k] = tact[2*k+1] || tact[2*k+2];
    end
  end

  assign pop_ready_o = (state_q == ST_FIND);
  assign upd_go      = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Compute wait, finish time and totals for the held job
  always_comb begin
    dispatch = (job_q.kind == KIND_DISPATCH);
    arr32    = {{(FreeW-TimeW){1'b0}}, job_q.arrival};
    if (best_q > arr32) begin
      wait_s = best_q - arr32;
      start  = best_q;
    end else begin
      wait_s = '0;
      start  = arr32;
    end
    svc_sec  = {6'd0, job_q.minutes} * SEC_PER_MIN;
    fin_sum  = {1'b0, start} + {{(FreeW-15){1'b0}}, svc_sec};
    fin      = fin_sum[FreeW] ? '1 : fin_sum[FreeW-1:0];
    sum_ext  = {1'b0, wait_sum_q} + {{(SumW-FreeW+1){1'b0}}, wait_s};
    bidx_ext = {3'd0, bidx_q};

    wait_sum_d = wait_sum_q;
    count_d    = count_q;
    if (upd_go && dispatch) begin
      wait_sum_d = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
      count_d    = (count_q == '1) ? count_q : count_q + 16'd1;
    end

    out_d.accepted     = dispatch;
    out_d.order_error  = (job_q.kind == KIND_ORDER);
    out_d.server_index = dispatch ? bidx_ext[2:0] : 3'd0;
    out_d.wait_seconds = dispatch ? wait_s : '0;
    out_d.total_wait   = wait_sum_d;
    out_d.served_count = count_d;
  end

  // Sequence: search on pop, update once the result register is free or being read
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_FIND: begin
        if (pop_valid_i) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          out_valid_d = 1'b1;
          state_d     = ST_FIND;
        end
      end
      default: state_d = ST_FIND;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FIND;
      out_valid_q <= 1'b0;
      wait_sum_q  <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wait_sum_q  <= wait_sum_d;
      count_q     <= count_d;
    end
  end

  // Hold the popped job and its search result; register the result
  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      job_q  <= pop_data_i;
      best_q <= tval[0];
      bidx_q <= tidx[0];
    end
    if (upd_go) begin
      out_q <= out_d;
    end
  end

  // Server free times: reload on open-time write, update on dispatch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
        free_q[i] <= {{(FreeW-TimeW){1'b0}}, OPEN_RESET};
      end
    end else if (reload_i) begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
        free_q[i] <= {{(FreeW-TimeW){1'b0}}, reload_time_i};
      end
    end else if (upd_go && dispatch) begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
        if (Lvl'(i) == bidx_q) begin
          free_q[i] <= fin;
        end
      end
    end
  end

endmodule

// ===== design/multi_server_earliest_free_dispatch_core.sv =====
// A job passes through a queue entry, the back end's job and search-result registers and
// the result register; the back end takes a new job only after it has written back the
// previous one to the server free-time registers (search and register, then write back).
// A two-entry queue decouples intake from dispatch; input stalls only when it is full.
// Reset (asynchronous, active low) restores register defaults, sets every server free at
// the open time, and clears last arrival, wait total and job count.
module multi_server_earliest_free_dispatch_core import msed_pkg::*; #(
  parameter int unsigned MAX_SERVERS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgIW-1:0] cfg_idx_i,
  input  logic [CfgDW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  job_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output job_out_t         out_data_o
);

  cfg_t     cfg_q, cfg_d;
  logic     reload;
  logic     push_valid;
  logic     push_ready;
  job_cls_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  job_cls_t pop_data;

  // Decode configuration writes
  always_comb begin
    cfg_d  = cfg_q;
    reload = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SERVERS_IN_USE: cfg_d.servers_in_use = cfg_wdata_i[3:0];
        CFG_OPEN_TIME: begin
          cfg_d.open_time = cfg_wdata_i[TimeW-1:0];
          reload          = 1'b1;
        end
        CFG_CUTOFF_TIME:    cfg_d.cutoff_time = cfg_wdata_i[TimeW-1:0];
        CFG_SERVICE_CAP:    cfg_d.service_cap = cfg_wdata_i[MinW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servers_in_use <= SERVERS_RESET;
      cfg_q.open_time      <= OPEN_RESET;
      cfg_q.cutoff_time    <= CUTOFF_RESET;
      cfg_q.service_cap    <= CAP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  msed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  msed_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  msed_back #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .reload_i      (reload),
    .reload_time_i (cfg_wdata_i[TimeW-1:0]),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule
